// File: sv/chn_pkg.sv
// Shared types and constants for the channel histogram normalizer.
// Used by every module of the block but chn_fifo; depends on nothing.
package chn_pkg;

	localparam int BIN_WIDTH        = 8;
	localparam int NUM_BINS         = 256;
	localparam int HEIGHT_WIDTH     = 8;
	localparam int OUT_COUNT_WIDTH  = 24;
	localparam int MAX_COUNT_WIDTH  = 32;
	localparam int DEF_COUNT_WIDTH  = 24;
	localparam int PIXEL_WIDTH      = 32;
	localparam int CMD_QUEUE_DEPTH  = 4;
	localparam int RES_QUEUE_DEPTH  = 2;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_LANE_SELECT = 2'd0;
	localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
	localparam logic [1:0] REG_CLAMP = 2'd2;

	localparam logic [1:0] LANE_RESET  = 2'd0;
	localparam logic [7:0] SCALE_RESET = 8'd100;
	localparam logic       CLAMP_RESET = 1'b0;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [BIN_WIDTH-1:0] bin;
	} cmd_t;

	typedef struct packed {
		logic [HEIGHT_WIDTH-1:0]    height;
		logic [OUT_COUNT_WIDTH-1:0] count;
		logic                       no_data;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// File: sv/chn_fifo.sv
// Small synchronous queue built from a register file.
// Standalone; DEPTH must be a power of two of at least two.
module chn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: sv/chn_front.sv
// Front end: accepts input beats, classifies the command and picks the pixel lane.
// Depends on chn_pkg and chn_fifo.
module chn_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        command,
	input  logic [chn_pkg::PIXEL_WIDTH-1:0]   pixel_word,
	input  logic [chn_pkg::BIN_WIDTH-1:0]     bin_index,
	input  logic [1:0]                        lane_select,
	input  logic                              cmd_pop,
	output logic                              cmd_valid,
	output chn_pkg::cmd_t                     cmd
);

	chn_pkg::cmd_t                 cmd_in;
	logic                          cmd_known;
	logic                          cmd_empty;
	logic [$bits(chn_pkg::cmd_t)-1:0] cmd_raw;

	always_comb begin
		cmd_in.op  = chn_pkg::OP_ADD;
		cmd_in.bin = bin_index;
		cmd_known  = 1'b1;
		unique case (command)
			chn_pkg::CMD_ADD: begin
				cmd_in.op  = chn_pkg::OP_ADD;
				cmd_in.bin = pixel_word[{lane_select, 3'b000} +: chn_pkg::BIN_WIDTH];
			end
			chn_pkg::CMD_READ: begin
				cmd_in.op = chn_pkg::OP_READ;
			end
			chn_pkg::CMD_CLEAR: begin
				cmd_in.op = chn_pkg::OP_CLEAR;
			end
			default: begin
				cmd_known = 1'b0;
			end
		endcase
	end

	chn_fifo #(
		.WIDTH($bits(chn_pkg::cmd_t)),
		.DEPTH(chn_pkg::CMD_QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && cmd_known),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd       = chn_pkg::cmd_t'(cmd_raw);
	assign cmd_valid = !cmd_empty;

endmodule

// File: sv/chn_div.sv
// Restoring divider giving an 8-bit quotient, one quotient bit per cycle.
// Depends on chn_pkg; the quotient must be known to fit in eight bits.
module chn_div #(
	parameter int COUNT_WIDTH = chn_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [COUNT_WIDTH+chn_pkg::HEIGHT_WIDTH-1:0] dividend,
	input  logic [COUNT_WIDTH-1:0]                      divisor,
	output logic                                        done,
	output logic [chn_pkg::HEIGHT_WIDTH-1:0]            quotient
);

	localparam int HW = chn_pkg::HEIGHT_WIDTH;
	localparam int PW = COUNT_WIDTH + HW;
	localparam int SW = $clog2(HW);

	logic [PW-1:0] rem_q;
	logic [PW-1:0] dsh_q;
	logic [HW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge       = (rem_q >= dsh_q);
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(HW - 1);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= PW'(divisor) << (HW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[HW-2:0], ge};
		end
	end

endmodule

// File: sv/chn_back.sv
// Back end: bin memory with valid bits, peak tracking, normalization and result queue.
// Depends on chn_pkg, chn_div and chn_fifo.
module chn_back #(
	parameter int COUNT_WIDTH = chn_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_valid,
	input  chn_pkg::cmd_t                          cmd,
	output logic                                   cmd_pop,
	input  logic [7:0]                             height_scale,
	input  logic                                   clamp_below_scale,
	input  logic                                   pop,
	output logic                                   empty,
	output logic [chn_pkg::HEIGHT_WIDTH-1:0]       bin_height,
	output logic [chn_pkg::OUT_COUNT_WIDTH-1:0]    bin_count,
	output logic                                   no_data
);

	localparam int HW = chn_pkg::HEIGHT_WIDTH;
	localparam int PW = COUNT_WIDTH + HW;

	chn_pkg::state_t state_q;
	chn_pkg::state_t state_d;

	logic [COUNT_WIDTH-1:0]      mem [chn_pkg::NUM_BINS];
	logic [chn_pkg::NUM_BINS-1:0] valid_q;
	logic [COUNT_WIDTH-1:0]      peak_q;
	logic [COUNT_WIDTH-1:0]      rd_data_q;
	logic                        rd_valid_q;
	logic [chn_pkg::BIN_WIDTH-1:0] bin_q;
	logic [COUNT_WIDTH-1:0]      cnt_q;
	logic [PW-1:0]               product_q;
	logic [HW-1:0]               h_q;
	logic                        nd_q;

	logic [COUNT_WIDTH-1:0]      cnt;
	logic [COUNT_WIDTH-1:0]      inc;
	logic                        mem_we;
	logic                        clear;
	logic                        div_start;
	logic                        div_done;
	logic [HW-1:0]               div_quo;
	logic                        res_push;
	logic                        res_full;
	logic [HW-1:0]               lim;
	chn_pkg::res_t               res_in;
	logic [$bits(chn_pkg::res_t)-1:0] res_raw;
	chn_pkg::res_t               res_out;
	logic [chn_pkg::MAX_COUNT_WIDTH-1:0] cnt_ext;

	assign cnt = rd_valid_q ? rd_data_q : '0;
	assign inc = (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : cnt + COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		clear     = 1'b0;
		div_start = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			chn_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						chn_pkg::OP_ADD:  state_d = chn_pkg::ST_ADD;
						chn_pkg::OP_READ: state_d = chn_pkg::ST_READ;
						default:          clear = 1'b1;
					endcase
				end
			end
			chn_pkg::ST_ADD: begin
				mem_we  = 1'b1;
				state_d = chn_pkg::ST_IDLE;
			end
			chn_pkg::ST_READ: begin
				state_d = chn_pkg::ST_START;
			end
			chn_pkg::ST_START: begin
				if (peak_q == '0) begin
					state_d = chn_pkg::ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = chn_pkg::ST_DIV;
				end
			end
			chn_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = chn_pkg::ST_OUT;
				end
			end
			chn_pkg::ST_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = chn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chn_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (clear) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (mem_we) begin
			valid_q[bin_q] <= 1'b1;
			if (inc > peak_q) begin
				peak_q <= inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[bin_q] <= inc;
		end
		rd_data_q <= mem[cmd.bin];
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= valid_q[cmd.bin];
		if (cmd_pop) begin
			bin_q <= cmd.bin;
		end
		if (state_q == chn_pkg::ST_READ) begin
			cnt_q     <= cnt;
			product_q <= PW'(cnt) * PW'(height_scale);
		end
		if (state_q == chn_pkg::ST_START) begin
			nd_q <= (peak_q == '0);
			h_q  <= '0;
		end else if (state_q == chn_pkg::ST_DIV && div_done) begin
			h_q <= div_quo;
		end
	end

	chn_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product_q),
		.divisor (peak_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign lim     = (height_scale == '0) ? '0 : height_scale - 8'd1;
	assign cnt_ext = chn_pkg::MAX_COUNT_WIDTH'(cnt_q);

	always_comb begin
		res_in.height  = (clamp_below_scale && (h_q > lim)) ? lim : h_q;
		res_in.count   = cnt_ext[chn_pkg::OUT_COUNT_WIDTH-1:0];
		res_in.no_data = nd_q;
	end

	chn_fifo #(
		.WIDTH($bits(chn_pkg::res_t)),
		.DEPTH(chn_pkg::RES_QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_raw),
		.empty  (empty)
	);

	assign res_out    = chn_pkg::res_t'(res_raw);
	assign bin_height = res_out.height;
	assign bin_count  = res_out.count;
	assign no_data    = res_out.no_data;

endmodule

// File: sv/channel_histogram_normalizer.sv
// Channel histogram normalizer: 256-bin histogram of one byte lane with normalized reads.
// An add is a bin memory read then a write, a clear acts when it is accepted, and a read is
// a memory read, a multiply, a divider start, the divider steps and a result write (the
// divider is skipped when the peak is zero; the write waits while the result queue is full).
// Reset is asynchronous: it empties both queues, marks every bin invalid (reads as zero),
// zeroes the peak and restores the configuration defaults; there is no clearing sweep.
module channel_histogram_normalizer #(
	parameter int COUNT_WIDTH = chn_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           command,
	input  logic [chn_pkg::PIXEL_WIDTH-1:0]      pixel_word,
	input  logic [chn_pkg::BIN_WIDTH-1:0]        bin_index,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [chn_pkg::HEIGHT_WIDTH-1:0]     bin_height,
	output logic [chn_pkg::OUT_COUNT_WIDTH-1:0]  bin_count,
	output logic                                 no_data,
	input  logic                                 cfg_write,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);

	logic [1:0]    lane_select_q;
	logic [7:0]    height_scale_q;
	logic          clamp_q;
	logic          cmd_valid;
	logic          cmd_pop;
	chn_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_select_q  <= chn_pkg::LANE_RESET;
			height_scale_q <= chn_pkg::SCALE_RESET;
			clamp_q        <= chn_pkg::CLAMP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				chn_pkg::REG_LANE_SELECT:  lane_select_q  <= cfg_data[1:0];
				chn_pkg::REG_HEIGHT_SCALE: height_scale_q <= cfg_data;
				chn_pkg::REG_CLAMP:        clamp_q        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	chn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.pixel_word (pixel_word),
		.bin_index  (bin_index),
		.lane_select(lane_select_q),
		.cmd_pop    (cmd_pop),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	chn_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop),
		.height_scale     (height_scale_q),
		.clamp_below_scale(clamp_q),
		.pop              (pop),
		.empty            (empty),
		.bin_height       (bin_height),
		.bin_count        (bin_count),
		.no_data          (no_data)
	);

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the channel histogram normalizer: directed and random
// add, read, clear and unused beats, checked against an in-bench histogram predictor.
// Depends on chn_pkg and channel_histogram_normalizer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_W = chn_pkg::DEF_COUNT_WIDTH;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 4000;
	localparam int DEEP_ADDS = 259;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  command;
	logic [31:0] pixel_word;
	logic [7:0]  bin_index;
	logic        empty;
	logic        pop;
	logic [7:0]  bin_height;
	logic [23:0] bin_count;
	logic        no_data;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	bit [COUNT_W-1:0] hist [chn_pkg::NUM_BINS];
	bit [COUNT_W-1:0] peak;
	bit [1:0]         lane;
	bit [7:0]         scale;
	bit               clamp;
	chn_pkg::res_t    pending_reads [$];
	int               mismatches;
	int               send_gap_pct;
	int               pop_stall_pct;

	channel_histogram_normalizer #(
		.COUNT_WIDTH(COUNT_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.pixel_word(pixel_word),
		.bin_index (bin_index),
		.empty     (empty),
		.pop       (pop),
		.bin_height(bin_height),
		.bin_count (bin_count),
		.no_data   (no_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= pop_stall_pct);
	end

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		chn_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("unexpected beat height=%0d count=%0d no_data=%0b",
					bin_height, bin_count, no_data));
			end else begin
				want = pending_reads.pop_front();
				if (bin_height !== want.height)
					report_mismatch($sformatf("bin_height %0d, want %0d", bin_height, want.height));
				if (bin_count !== want.count)
					report_mismatch($sformatf("bin_count %0d, want %0d", bin_count, want.count));
				if (no_data !== want.no_data)
					report_mismatch($sformatf("no_data %0b, want %0b", no_data, want.no_data));
			end
		end
	end

	function automatic void predict_beat(logic [1:0] cmd, logic [31:0] word, logic [7:0] idx);
		bit [7:0]          b;
		longint unsigned   h;
		longint unsigned   lim;
		chn_pkg::res_t     r;
		case (cmd)
			chn_pkg::CMD_ADD: begin
				b = word[8*lane +: 8];
				if (hist[b] != '1)
					hist[b]++;
				if (hist[b] > peak)
					peak = hist[b];
			end
			chn_pkg::CMD_READ: begin
				r.count = 24'(hist[idx]);
				r.height = '0;
				r.no_data = (peak == 0);
				if (peak != 0) begin
					h = hist[idx];
					h = h * scale / peak;
					lim = (scale == 0) ? 64'd0 : 64'(scale) - 64'd1;
					if (clamp && h > lim)
						h = lim;
					r.height = h[7:0];
				end
				pending_reads.push_back(r);
			end
			chn_pkg::CMD_CLEAR: begin
				foreach (hist[i])
					hist[i] = '0;
				peak = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_beat(logic [1:0] cmd, logic [31:0] word, logic [7:0] idx);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		pixel_word <= word;
		bin_index <= idx;
		do @(posedge clk); while (full);
		predict_beat(cmd, word, idx);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		push <= 1'b0;
		while (pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reads.size() != 0) begin
			report_mismatch($sformatf("%0d read beats never returned", pending_reads.size()));
			pending_reads.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			chn_pkg::REG_LANE_SELECT: begin
				lane = data[1:0];
			end
			chn_pkg::REG_HEIGHT_SCALE: begin
				scale = data;
			end
			chn_pkg::REG_CLAMP: begin
				clamp = data[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(bit [1:0] new_lane, bit [7:0] new_scale, bit new_clamp);
		drain_results();
		write_reg(chn_pkg::REG_LANE_SELECT, 8'(new_lane));
		write_reg(chn_pkg::REG_HEIGHT_SCALE, new_scale);
		write_reg(chn_pkg::REG_CLAMP, 8'(new_clamp));
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic test_empty_reads();
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h00);
		send_beat(chn_pkg::CMD_READ, 32'hFFFF_FFFF, 8'hFF);
		send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
		send_beat(chn_pkg::CMD_CLEAR, 32'h0000_0000, 8'h00);
		send_beat(chn_pkg::CMD_READ, 32'h1234_5678, 8'h80);
	endtask

	task automatic test_lane_select();
		send_beat(chn_pkg::CMD_ADD, 32'hFFFF_FFFF, 8'h00);
		send_beat(chn_pkg::CMD_ADD, 32'h0000_0000, 8'hFF);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'hFF);
		send_beat(chn_pkg::CMD_READ, 32'hFFFF_FFFF, 8'h00);
		for (int k = 0; k < 4; k++) begin
			set_config(2'(k), 8'd100, 1'b0);
			send_beat(chn_pkg::CMD_ADD, 32'h8040_2010, 8'h00);
			send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'(8'h10 << k));
		end
	endtask

	task automatic test_height_scaling();
		send_beat(chn_pkg::CMD_CLEAR, 32'h0000_0000, 8'h00);
		set_config(2'd0, 8'd255, 1'b0);
		repeat (3) send_beat(chn_pkg::CMD_ADD, 32'h5A5A_5A11, 8'h00);
		send_beat(chn_pkg::CMD_ADD, 32'h0000_0022, 8'h00);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h11);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h22);
		set_config(2'd0, 8'd255, 1'b1);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h11);
		set_config(2'd0, 8'd1, 1'b1);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h11);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h22);
		set_config(2'd0, 8'd0, 1'b0);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h11);
		set_config(2'd0, 8'd0, 1'b1);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h11);
	endtask

	task automatic test_deep_bin();
		logic [31:0] w;
		set_config(2'd2, 8'd7, 1'b1);
		send_beat(chn_pkg::CMD_CLEAR, 32'h0000_0000, 8'h00);
		repeat (DEEP_ADDS) begin
			w = $urandom;
			w[23:16] = 8'hA5;
			send_beat(chn_pkg::CMD_ADD, w, 8'($urandom));
		end
		send_beat(chn_pkg::CMD_ADD, 32'h0033_0000, 8'h00);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'hA5);
		send_beat(chn_pkg::CMD_READ, 32'h0000_0000, 8'h33);
	endtask

	task automatic run_random_segment(int beats);
		logic [31:0] w;
		int          pick;
		bit [7:0]    hot [8];
		foreach (hot[i])
			hot[i] = 8'($urandom);
		repeat (beats) begin
			w = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if (pick < 48)
					w[8*lane +: 8] = hot[$urandom_range(0, 7)];
				send_beat(chn_pkg::CMD_ADD, w, 8'($urandom));
			end else if (pick < 90) begin
				send_beat(chn_pkg::CMD_READ, w,
					(pick < 80) ? hot[$urandom_range(0, 7)] : 8'($urandom));
			end else if (pick < 93) begin
				send_beat(chn_pkg::CMD_CLEAR, w, 8'($urandom));
			end else if (pick < 96) begin
				send_beat(CMD_UNUSED, w, 8'($urandom));
			end else begin
				send_beat(chn_pkg::CMD_ADD, w, 8'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic();
		bit [7:0] scales [6];
		scales = '{8'd255, 8'd1, 8'd200, 8'd37, 8'd128, 8'd100};
		for (int seg = 0; seg < 6; seg++) begin
			set_config(2'(seg), (seg == 4) ? 8'($urandom_range(1, 255)) : scales[seg],
				1'(seg));
			case (seg / 2)
				0: begin
					send_gap_pct = 7;
					pop_stall_pct = 47;
				end
				1: begin
					send_gap_pct = 47;
					pop_stall_pct = 7;
				end
				default: begin
					send_gap_pct = 0;
					pop_stall_pct = 0;
				end
			endcase
			run_random_segment(150);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		command = chn_pkg::CMD_ADD;
		pixel_word = '0;
		bin_index = '0;
		cfg_write = 1'b0;
		cfg_index = chn_pkg::REG_LANE_SELECT;
		cfg_data = '0;
		mismatches = 0;
		send_gap_pct = 7;
		pop_stall_pct = 47;
		lane = chn_pkg::LANE_RESET;
		scale = chn_pkg::SCALE_RESET;
		clamp = chn_pkg::CLAMP_RESET;
		peak = '0;
		foreach (hist[i])
			hist[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_reads();
		test_lane_select();
		test_height_scaling();
		test_deep_bin();
		test_random_traffic();
		drain_results();

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
